@@ hw/rtl/sor_pkg.sv @@
`timescale 1ns / 1ps

package sor_pkg;

    // Default geometry and word width
    localparam int DEF_MAX_ROWS    = 16;
    localparam int DEF_MAX_COLUMNS = 16;
    localparam int DEF_DATA_WIDTH  = 32;

    // Fixed port widths
    localparam int RESULT_W    = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = CFG_INDEX_W'(1);

    // Item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    // Walk headings, clockwise
    localparam logic [1:0] HEAD_RIGHT = 2'd0;
    localparam logic [1:0] HEAD_DOWN  = 2'd1;
    localparam logic [1:0] HEAD_LEFT  = 2'd2;
    localparam logic [1:0] HEAD_UP    = 2'd3;

    // Memory command from the walk controller
    typedef struct packed {
        logic mem_en;    // access the store this cycle
        logic mem_we;    // write (else read)
        logic last;      // read is the final element of the spiral
    } sor_cmd_t;

endpackage

@@ hw/rtl/sor_store.sv @@
`timescale 1ns / 1ps

module sor_store
    import sor_pkg::*;
#(
    parameter int DEPTH      = DEF_MAX_ROWS * DEF_MAX_COLUMNS,
    parameter int ADDR_W     = $clog2(DEF_MAX_ROWS * DEF_MAX_COLUMNS),
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                  clk,
    input  sor_cmd_t              cmd,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Single-port RAM, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_en)
        begin
            if (cmd.mem_we)
            begin
                mem[addr] <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/sor_walk.sv @@
`timescale 1ns / 1ps

module sor_walk
    import sor_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int ADDR_W      = $clog2(DEF_MAX_ROWS * DEF_MAX_COLUMNS)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   mode,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output sor_cmd_t               cmd,
    output logic [ADDR_W-1:0]      addr
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int COLS_W = $clog2(MAX_COLUMNS + 1);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PROD_W = ROW_W + COLS_W + 1;

    logic [ROWS_W-1:0] rows_reg,   rows_next;
    logic [COLS_W-1:0] cols_reg,   cols_next;
    logic [ADDR_W-1:0] slot_reg,   slot_next;
    logic [ROW_W-1:0]  row_reg,    row_next;
    logic [COL_W-1:0]  col_reg,    col_next;
    logic [1:0]        head_reg,   head_next;
    logic [ROW_W-1:0]  top_reg,    top_next;
    logic [ROW_W-1:0]  bottom_reg, bottom_next;
    logic [COL_W-1:0]  left_reg,   left_next;
    logic [COL_W-1:0]  right_reg,  right_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  slot_inc;
    logic [PROD_W-1:0] lin_addr;
    logic              is_last;
    logic              restart;
    logic [ROWS_W-1:0] rows_cfg;
    logic [COLS_W-1:0] cols_cfg;

    assign total     = CNT_W'(CNT_W'(rows_reg) * CNT_W'(cols_reg));
    assign count_inc = count_reg + CNT_W'(1);
    assign slot_inc  = CNT_W'(slot_reg) + CNT_W'(1);
    assign is_last   = (count_inc >= total);
    assign lin_addr  = PROD_W'(row_reg) * PROD_W'(cols_reg) + PROD_W'(col_reg);

    // Zero acts as one, large values saturate
    assign rows_cfg = (cfg_data == '0) ? ROWS_W'(1) :
                      ((32'(cfg_data) > 32'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : ROWS_W'(cfg_data));
    assign cols_cfg = (cfg_data == '0) ? COLS_W'(1) :
                      ((32'(cfg_data) > 32'(MAX_COLUMNS)) ? COLS_W'(MAX_COLUMNS)
                                                            : COLS_W'(cfg_data));

    always_comb
    begin
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        slot_next   = slot_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        head_next   = head_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        count_next  = count_reg;
        restart     = 1'b0;
        cmd         = '0;
        addr        = ADDR_W'(lin_addr);

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:
                begin
                    rows_next = rows_cfg;
                    slot_next = '0;
                    restart   = 1'b1;
                end
                CFG_COLUMN_COUNT:
                begin
                    cols_next = cols_cfg;
                    slot_next = '0;
                    restart   = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept && mode == MODE_WRITE)
        begin
            cmd.mem_en = 1'b1;
            cmd.mem_we = 1'b1;
            addr       = slot_reg;
            slot_next  = (slot_inc >= total) ? '0 : ADDR_W'(slot_inc);
        end
        else if (accept)
        begin
            cmd.mem_en = 1'b1;
            cmd.last   = is_last;
            count_next = count_inc;
            if (is_last)
            begin
                restart = 1'b1;
            end
            else
            begin
                // Advance one step, turning clockwise at a bound
                case (head_reg)
                    HEAD_RIGHT:
                    begin
                        if (col_reg < right_reg)
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                        else
                        begin
                            top_next  = top_reg + ROW_W'(1);
                            head_next = HEAD_DOWN;
                            row_next  = row_reg + ROW_W'(1);
                        end
                    end
                    HEAD_DOWN:
                    begin
                        if (row_reg < bottom_reg)
                        begin
                            row_next = row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            right_next = right_reg - COL_W'(1);
                            head_next  = HEAD_LEFT;
                            col_next   = col_reg - COL_W'(1);
                        end
                    end
                    HEAD_LEFT:
                    begin
                        if (col_reg > left_reg)
                        begin
                            col_next = col_reg - COL_W'(1);
                        end
                        else
                        begin
                            bottom_next = bottom_reg - ROW_W'(1);
                            head_next   = HEAD_UP;
                            row_next    = row_reg - ROW_W'(1);
                        end
                    end
                    default:
                    begin
                        if (row_reg > top_reg)
                        begin
                            row_next = row_reg - ROW_W'(1);
                        end
                        else
                        begin
                            left_next = left_reg + COL_W'(1);
                            head_next = HEAD_RIGHT;
                            col_next  = col_reg + COL_W'(1);
                        end
                    end
                endcase
            end
        end

        if (restart)
        begin
            row_next    = '0;
            col_next    = '0;
            head_next   = HEAD_RIGHT;
            top_next    = '0;
            bottom_next = ROW_W'(rows_next - ROWS_W'(1));
            left_next   = '0;
            right_next  = COL_W'(cols_next - COLS_W'(1));
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= ROWS_W'(1);
            cols_reg   <= COLS_W'(1);
            slot_reg   <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            head_reg   <= HEAD_RIGHT;
            top_reg    <= '0;
            bottom_reg <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rows_reg   <= rows_next;
            cols_reg   <= cols_next;
            slot_reg   <= slot_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            head_reg   <= head_next;
            top_reg    <= top_next;
            bottom_reg <= bottom_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/spiral_order_reader_unit.sv @@
`timescale 1ns / 1ps

// Spiral order reader. Write words (mode 0) fill a rows by columns matrix in
// row-major order; fetch words (mode 1) return the matrix in clockwise spiral
// order starting at the top left, with last_of_spiral set on the final
// element, after which the walk starts over. A new word may be started on
// every clock, so busy never rises. A fetch reads the element RAM at the
// edge that accepts it and the result shows on spiral_value with done high
// for exactly one cycle right after: the receiver cannot stall, so it must
// take the word in that cycle. Writes give no result. Writing row_count or
// column_count restarts the walk and the write position; do so only with no
// word in flight. Fetching a matrix entry that was never written returns an
// unknown value.

module spiral_order_reader_unit
    import sor_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    // Command side
    input  logic                         start,
    output logic                         busy,
    input  logic                         mode,
    input  logic signed [DATA_WIDTH-1:0] element_value,

    // Result side
    output logic                         done,
    output logic signed [RESULT_W-1:0]   spiral_value,
    output logic                         last_of_spiral,

    // Configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sor_cmd_t              cmd;
    logic [ADDR_W-1:0]     mem_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  accept;
    logic                  done_reg;
    logic                  last_reg;

    // One word per cycle, no stall source
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Position, bounds, write slot and sizes
    sor_walk #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .ADDR_W      (ADDR_W)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (mode),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .addr      (mem_addr)
    );

    // Element RAM, registered read
    sor_store #(
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .cmd     (cmd),
        .addr    (mem_addr),
        .wr_data (element_value),
        .rd_data (rd_data)
    );

    // Line the strobe and last flag up with the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.mem_en && !cmd.mem_we;
            last_reg <= cmd.last;
        end
    end

    assign done           = done_reg;
    assign last_of_spiral = last_reg;
    // Stored word is zero-extended or cut to the result width
    assign spiral_value   = RESULT_W'(rd_data);

endmodule
